// File: rtl/owsm_pkg.sv
// shared types and constants for the omni wheel speed mixer
`default_nettype none

package owsm_pkg;

	localparam int DEF_SPEED_FRAC_BITS = 12;
	localparam int DEF_RATE_FRAC_BITS  = 4;
	localparam int DEF_QUEUE_DEPTH     = 4;

	localparam int NUM_WHEELS = 4;
	localparam int FIELD_W    = 16;
	localparam int GAIN_W     = 16;
	localparam int LIM_W      = 15;
	localparam int WHEEL_W    = 32;
	localparam int MAG_W      = 31;
	localparam int QUO_W      = 15;
	localparam int NUM_W      = MAG_W + LIM_W;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;

	localparam logic [LIM_W-1:0] MAX_SPEED_RESET = 15'h7fff;

	typedef enum logic {
		REG_ROT_GAIN  = 1'b0,
		REG_MAX_SPEED = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] vel_x;
		logic signed [FIELD_W-1:0] vel_y;
		logic signed [FIELD_W-1:0] yaw_rate;
	} cmd_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] wheel0_speed;
		logic signed [FIELD_W-1:0] wheel1_speed;
		logic signed [FIELD_W-1:0] wheel2_speed;
		logic signed [FIELD_W-1:0] wheel3_speed;
		logic                      was_limited;
	} res_t;

	typedef struct packed {
		logic [GAIN_W-1:0] rotation_gain;
		logic [LIM_W-1:0]  speed_limit;
	} cfg_t;

	typedef logic [NUM_WHEELS-1:0][MAG_W-1:0] mag_vec_t;
	typedef logic [NUM_WHEELS-1:0][QUO_W-1:0] quo_vec_t;

	// one classified command between front and back
	typedef struct packed {
		mag_vec_t              mag;
		logic [NUM_WHEELS-1:0] neg;
		logic [MAG_W-1:0]      peak;
		logic                  limited;
	} entry_t;

	// state of one divider stage, four lanes
	typedef struct packed {
		logic                  valid;
		logic                  limited;
		logic [NUM_WHEELS-1:0] neg;
		logic [MAG_W-1:0]      peak;
		mag_vec_t              rem;
		quo_vec_t              low;
		quo_vec_t              quo;
	} dstep_t;

endpackage

`default_nettype wire

// File: rtl/owsm_front.sv
// front pipeline: wheel mixing, magnitudes, peak and limit decision
`default_nettype none

module owsm_front #(
	parameter int SPEED_FRAC_BITS = owsm_pkg::DEF_SPEED_FRAC_BITS,
	parameter int RATE_FRAC_BITS  = owsm_pkg::DEF_RATE_FRAC_BITS
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire owsm_pkg::cfg_t  cfg,
	input  wire logic            cmd_valid,
	output logic                 cmd_ready,
	input  wire owsm_pkg::cmd_t  cmd,
	output logic                 ent_valid,
	input  wire logic            ent_ready,
	output owsm_pkg::entry_t     ent
);

	localparam int NW         = owsm_pkg::NUM_WHEELS;
	localparam int SUM_W      = owsm_pkg::FIELD_W + 1;
	localparam int MIX_PROD_W = 35;
	localparam int ROT_PROD_W = 34;
	localparam int MIX_SHIFT  = 16;
	localparam int MIX_W      = 18;
	localparam int WHEEL_W    = owsm_pkg::WHEEL_W;
	localparam int MAG_W      = owsm_pkg::MAG_W;
	localparam int ROT_SHIFT  = 16 + RATE_FRAC_BITS - SPEED_FRAC_BITS;

	localparam logic signed [17:0] HALF_SQRT2_Q16 = 18'sd46341;
	localparam logic signed [MIX_PROD_W-1:0] MIX_HALF =
		MIX_PROD_W'(1) << (MIX_SHIFT - 1);
	localparam logic signed [ROT_PROD_W-1:0] ROT_HALF =
		ROT_PROD_W'(1) << (ROT_SHIFT - 1);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [SUM_W-1:0]      vsum, vdif;
	logic signed [SUM_W-1:0]      gain_x;
	logic signed [MIX_PROD_W-1:0] psum_c, pdif_c;
	logic signed [ROT_PROD_W-1:0] prot_c;
	logic signed [MIX_PROD_W-1:0] psum_s1, pdif_s1;
	logic signed [ROT_PROD_W-1:0] prot_s1;

	logic signed [MIX_PROD_W-1:0] pv [NW];
	logic signed [MIX_W-1:0]      mix_c [NW];
	logic signed [WHEEL_W-1:0]    rot_c;
	logic signed [MIX_W-1:0]      mix_s2 [NW];
	logic signed [WHEEL_W-1:0]    rot_s2;

	logic signed [WHEEL_W-1:0]    w_c [NW];
	logic signed [WHEEL_W-1:0]    w_s3 [NW];

	owsm_pkg::mag_vec_t           mag_c;
	logic [NW-1:0]                neg_c;
	owsm_pkg::mag_vec_t           mag_s4;
	logic [NW-1:0]                neg_s4;

	logic [MAG_W-1:0]             pm0, pm1, peak_c;
	logic [NW-1:0]                over;
	owsm_pkg::entry_t             ent_s5;

	// whole front moves together; the queue absorbs back pressure
	assign en        = !v_s5 || ent_ready;
	assign cmd_ready = en;
	assign ent_valid = v_s5;
	assign ent       = ent_s5;

	// stage 1: products
	always_comb begin
		vsum   = SUM_W'(cmd.vel_x) + SUM_W'(cmd.vel_y);
		vdif   = SUM_W'(cmd.vel_x) - SUM_W'(cmd.vel_y);
		gain_x = signed'({1'b0, cfg.rotation_gain});
		psum_c = vsum * HALF_SQRT2_Q16;
		pdif_c = vdif * HALF_SQRT2_Q16;
		prot_c = cmd.yaw_rate * gain_x;
	end

	// stage 2: round to speed units, halves up
	always_comb begin
		pv[0] = pdif_s1;
		pv[1] = -psum_s1;
		pv[2] = -pdif_s1;
		pv[3] = psum_s1;
		for (int i = 0; i < NW; i++) begin
			mix_c[i] = MIX_W'((pv[i] + MIX_HALF) >>> MIX_SHIFT);
		end
		rot_c = WHEEL_W'((prot_s1 + ROT_HALF) >>> ROT_SHIFT);
	end

	// stage 3: wheel speeds
	always_comb begin
		for (int i = 0; i < NW; i++) begin
			w_c[i] = WHEEL_W'(mix_s2[i]) - rot_s2;
		end
	end

	// stage 4: sign and magnitude
	always_comb begin
		for (int i = 0; i < NW; i++) begin
			neg_c[i] = w_s3[i][WHEEL_W-1];
			mag_c[i] = MAG_W'(neg_c[i] ? -w_s3[i] : w_s3[i]);
		end
	end

	// stage 5: peak magnitude and limit flag
	always_comb begin
		pm0    = (mag_s4[0] > mag_s4[1]) ? mag_s4[0] : mag_s4[1];
		pm1    = (mag_s4[2] > mag_s4[3]) ? mag_s4[2] : mag_s4[3];
		peak_c = (pm0 > pm1) ? pm0 : pm1;
		for (int i = 0; i < NW; i++) begin
			over[i] = mag_s4[i] > MAG_W'(cfg.speed_limit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= cmd_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			psum_s1 <= psum_c;
			pdif_s1 <= pdif_c;
			prot_s1 <= prot_c;
			mix_s2  <= mix_c;
			rot_s2  <= rot_c;
			w_s3    <= w_c;
			mag_s4  <= mag_c;
			neg_s4  <= neg_c;
			ent_s5.mag     <= mag_s4;
			ent_s5.neg     <= neg_s4;
			ent_s5.peak    <= peak_c;
			ent_s5.limited <= |over;
		end
	end

endmodule

`default_nettype wire

// File: rtl/owsm_queue.sv
// short word queue between the front and back pipelines
`default_nettype none

module owsm_queue #(
	parameter int DEPTH = owsm_pkg::DEF_QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_ready,
	input  wire owsm_pkg::entry_t  push_data,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output owsm_pkg::entry_t       pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	owsm_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push, pop;

	assign push_ready = cnt_q != CNT_W'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// File: rtl/owsm_div_step.sv
// one restoring division step for four wheel lanes
`default_nettype none

module owsm_div_step (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire owsm_pkg::dstep_t  din,
	output owsm_pkg::dstep_t       dout
);

	localparam int NW    = owsm_pkg::NUM_WHEELS;
	localparam int MAG_W = owsm_pkg::MAG_W;
	localparam int QUO_W = owsm_pkg::QUO_W;

	logic [NW-1:0][MAG_W:0] trial;
	logic [NW-1:0]          ge;
	owsm_pkg::dstep_t       nxt;
	owsm_pkg::dstep_t       step_q;

	assign dout = step_q;

	// unlimited words carry their magnitude in quo and pass untouched
	always_comb begin
		nxt = din;
		for (int i = 0; i < NW; i++) begin
			trial[i] = {din.rem[i], din.low[i][QUO_W-1]};
			ge[i]    = trial[i] >= {1'b0, din.peak};
			if (din.limited) begin
				nxt.rem[i] = ge[i] ? MAG_W'(trial[i] - {1'b0, din.peak})
				                   : trial[i][MAG_W-1:0];
				nxt.low[i] = {din.low[i][QUO_W-2:0], 1'b0};
				nxt.quo[i] = {din.quo[i][QUO_W-2:0], ge[i]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (en) begin
			step_q <= nxt;
		end
	end

endmodule

`default_nettype wire

// File: rtl/owsm_back.sv
// back pipeline: scale by limit over peak, apply sign, output register
`default_nettype none

module owsm_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire owsm_pkg::cfg_t    cfg,
	input  wire logic              ent_valid,
	output logic                   ent_ready,
	input  wire owsm_pkg::entry_t  ent,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output owsm_pkg::res_t         res
);

	localparam int NW      = owsm_pkg::NUM_WHEELS;
	localparam int MAG_W   = owsm_pkg::MAG_W;
	localparam int QUO_W   = owsm_pkg::QUO_W;
	localparam int NUM_W   = owsm_pkg::NUM_W;
	localparam int WHEEL_W = owsm_pkg::WHEEL_W;
	localparam int FIELD_W = owsm_pkg::FIELD_W;

	localparam logic signed [WHEEL_W-1:0] SAT_HI = 32767;
	localparam logic signed [WHEEL_W-1:0] SAT_LO = -32768;

	function automatic logic signed [FIELD_W-1:0] sat16(input logic signed [WHEEL_W-1:0] x);
		logic signed [FIELD_W-1:0] r;
		if (x > SAT_HI) begin
			r = SAT_HI[FIELD_W-1:0];
		end else if (x < SAT_LO) begin
			r = SAT_LO[FIELD_W-1:0];
		end else begin
			r = x[FIELD_W-1:0];
		end
		return r;
	endfunction

	logic                      en;
	logic [NUM_W-1:0]          num [NW];
	owsm_pkg::dstep_t          d_c;
	owsm_pkg::dstep_t          d_s1;
	owsm_pkg::dstep_t          dv [QUO_W+1];
	owsm_pkg::dstep_t          last;
	logic signed [WHEEL_W-1:0] val [NW];
	logic signed [FIELD_W-1:0] spd [NW];
	owsm_pkg::res_t            res_c;
	owsm_pkg::res_t            res_q;
	logic                      res_valid_q;

	assign en        = !res_valid_q || res_ready;
	assign ent_ready = en;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// numerator magnitude * limit; quotient stays below 2^15
	always_comb begin
		d_c         = '0;
		d_c.valid   = ent_valid;
		d_c.limited = ent.limited;
		d_c.neg     = ent.neg;
		d_c.peak    = ent.peak;
		for (int i = 0; i < NW; i++) begin
			num[i] = ent.mag[i] * cfg.speed_limit;
			if (ent.limited) begin
				d_c.rem[i] = num[i][NUM_W-1:QUO_W];
				d_c.low[i] = num[i][QUO_W-1:0];
			end else begin
				d_c.quo[i] = ent.mag[i][QUO_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_s1 <= '0;
		end else if (en) begin
			d_s1 <= d_c;
		end
	end

	assign dv[0] = d_s1;

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		owsm_div_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (dv[k]),
			.dout   (dv[k+1])
		);
	end

	assign last = dv[QUO_W];

	always_comb begin
		for (int i = 0; i < NW; i++) begin
			val[i] = signed'(WHEEL_W'(last.quo[i]));
			spd[i] = sat16(last.neg[i] ? -val[i] : val[i]);
		end
		res_c.wheel0_speed = spd[0];
		res_c.wheel1_speed = spd[1];
		res_c.wheel2_speed = spd[2];
		res_c.wheel3_speed = spd[3];
		res_c.was_limited  = last.limited;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_c;
		end
	end

endmodule

`default_nettype wire

// File: rtl/omni_wheel_speed_mixer.sv
// top level: register port, front pipeline, queue and back pipeline
// throughput: one command per cycle while the result is not stalled; the 15-step pipelined
//   divider and the five-stage front each take a new word every cycle unless stalled
// the front queue lets the front keep accepting while the result is stalled, until the queue fills
// reset: asynchronous, clears all valids and queue pointers, rotation_gain to 0
//   and speed_limit to 32767
`default_nettype none

module omni_wheel_speed_mixer #(
	parameter int SPEED_FRAC_BITS = owsm_pkg::DEF_SPEED_FRAC_BITS,
	parameter int RATE_FRAC_BITS  = owsm_pkg::DEF_RATE_FRAC_BITS,
	parameter int QUEUE_DEPTH     = owsm_pkg::DEF_QUEUE_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [owsm_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [owsm_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [owsm_pkg::CFG_DATA_W-1:0] prdata,
	output logic                                 pready,
	input  wire logic                            cmd_valid,
	output logic                                 cmd_ready,
	input  wire owsm_pkg::cmd_t                  cmd_data,
	output logic                                 res_valid,
	input  wire logic                            res_ready,
	output owsm_pkg::res_t                       res_data
);

	localparam int GAIN_W = owsm_pkg::GAIN_W;
	localparam int LIM_W  = owsm_pkg::LIM_W;
	localparam int DATA_W = owsm_pkg::CFG_DATA_W;

	owsm_pkg::cfg_t     cfg_q;
	owsm_pkg::reg_idx_t reg_idx;
	logic               wr_en;

	logic               fq_valid, fq_ready;
	owsm_pkg::entry_t   fq_data;
	logic               qb_valid, qb_ready;
	owsm_pkg::entry_t   qb_data;

	assign pready  = 1'b1;
	assign reg_idx = owsm_pkg::reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotation_gain <= '0;
			cfg_q.speed_limit   <= owsm_pkg::MAX_SPEED_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				owsm_pkg::REG_ROT_GAIN: begin
					cfg_q.rotation_gain <= pwdata[GAIN_W-1:0];
				end
				owsm_pkg::REG_MAX_SPEED: begin
					cfg_q.speed_limit <= pwdata[LIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			owsm_pkg::REG_ROT_GAIN:  prdata = DATA_W'(cfg_q.rotation_gain);
			owsm_pkg::REG_MAX_SPEED: prdata = DATA_W'(cfg_q.speed_limit);
			default:                 prdata = '0;
		endcase
	end

	owsm_front #(
		.SPEED_FRAC_BITS (SPEED_FRAC_BITS),
		.RATE_FRAC_BITS  (RATE_FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd_data),
		.ent_valid (fq_valid),
		.ent_ready (fq_ready),
		.ent       (fq_data)
	);

	owsm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_data)
	);

	owsm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.ent_valid (qb_valid),
		.ent_ready (qb_ready),
		.ent       (qb_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res_data)
	);

endmodule

`default_nettype wire

// File: rtl/owsm_checker.sv
// port-level checker for the omni wheel speed mixer, bound to the top level
`default_nettype none

module owsm_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           cmd_valid,
	input wire logic           cmd_ready,
	input wire logic           res_valid,
	input wire logic           res_ready,
	input wire owsm_pkg::res_t res_data
);

	localparam int PEND_W = 8;
	localparam logic signed [owsm_pkg::FIELD_W-1:0] MOST_NEG = 16'sh8000;

	logic [PEND_W-1:0] pending_q;
	logic              cmd_acc, res_acc;

	assign cmd_acc = cmd_valid && cmd_ready;
	assign res_acc = res_valid && res_ready;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (cmd_acc && !res_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (res_acc && !cmd_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result word changed or dropped while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pending_q != '0)
		else $error("result word with no command outstanding");

	// no result word at the first edge after reset is released
	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !res_valid)
		else $error("result valid coming out of reset");

	// limited or not, every speed magnitude stays within 32767
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.wheel0_speed != MOST_NEG
			&& res_data.wheel1_speed != MOST_NEG
			&& res_data.wheel2_speed != MOST_NEG
			&& res_data.wheel3_speed != MOST_NEG)
		else $error("wheel speed outside the magnitude range");

endmodule

bind omni_wheel_speed_mixer owsm_checker u_checker (.*);

`default_nettype wire
